@@ hdl/mh_pkg.sv @@
// ----------------------------------------------------------------------------
// mh_pkg
// Shared widths, constants, types and the arctangent table of the compass
// heading pipeline.
// ----------------------------------------------------------------------------
package mh_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    localparam int SAMPLE_W   = 16;
    localparam int IN_TDATA_W = 2 * SAMPLE_W;
    localparam int DECL_W     = 15;
    localparam int DECL_SHIFT = 10;
    localparam int PRE_SHIFT  = 8;
    localparam int HEAD_W     = 9;
    localparam int FRAC_W     = 16;
    localparam int OUT_TDATA_W = 16;

    // Vector components and angle accumulator widths.
    localparam int XW = 27;
    localparam int ZW = 27;
    localparam int TW = 28;

    localparam logic [ZW-1:0] QUARTER_TURN = ZW'(5898240);
    localparam logic [ZW-1:0] HALF_TURN    = ZW'(11796480);
    localparam logic [ZW-1:0] THREE_QUARTER_TURN = ZW'(17694720);
    localparam logic [TW-1:0] FULL_TURN    = TW'(23592960);

    localparam logic [DECL_W-1:0] DECL_RESET = DECL_W'(548);

    typedef struct packed {
        logic                 bypass;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } mh_vec_t;

    function automatic logic [ZW-1:0] atan_entry(input int unsigned idx);
        logic [ZW-1:0] val;
        case (idx)
            0:       val = ZW'(2949120);
            1:       val = ZW'(1740967);
            2:       val = ZW'(919879);
            3:       val = ZW'(466945);
            4:       val = ZW'(234379);
            5:       val = ZW'(117304);
            6:       val = ZW'(58666);
            7:       val = ZW'(29335);
            8:       val = ZW'(14668);
            9:       val = ZW'(7334);
            10:      val = ZW'(3667);
            11:      val = ZW'(1833);
            12:      val = ZW'(917);
            13:      val = ZW'(458);
            14:      val = ZW'(229);
            15:      val = ZW'(115);
            16:      val = ZW'(57);
            17:      val = ZW'(29);
            18:      val = ZW'(14);
            19:      val = ZW'(7);
            20:      val = ZW'(4);
            21:      val = ZW'(2);
            22:      val = ZW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ hdl/magnetometer_heading.sv @@
// ----------------------------------------------------------------------------
// magnetometer_heading
// Compass heading from one X/Y magnetometer sample by a pipelined CORDIC.
// ----------------------------------------------------------------------------
// A sample enters on the slave stream as one transaction: X in tdata[15:0]
// and Y in tdata[31:16], both two's complement. Each sample yields exactly
// one transaction on the master stream carrying the heading in whole
// degrees, 0 to 359, with the declination added and truncated.
// The declination is a signed value in 1/64 degree written through the
// cfg channel, which is always ready; it should only be written while no
// samples are in flight.
// From acceptance to m_axis_tvalid a sample passes one input stage, one
// CORDIC cell per iteration, a declination adder and the output register.
// Every stage has its own handshake, so one sample per cycle is taken in
// steady state while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling until the chain is full; only then does
// s_axis_tready fall. Reset empties the pipeline and restores the
// declination to 548/64 degree, 8 degrees 33.75 minutes.
// ----------------------------------------------------------------------------
module magnetometer_heading
#(
    parameter int CORDIC_STEPS = mh_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // x_sample [15:0], y_sample [31:16]
    input  logic [mh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // heading_deg [8:0], zero padding above
    output logic [mh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mh_pkg::DECL_W-1:0]         cfg_data
);

    localparam int NSTEP = (CORDIC_STEPS > mh_pkg::TABLE_LEN) ? mh_pkg::TABLE_LEN
                                                              : CORDIC_STEPS;

    logic [mh_pkg::DECL_W-1:0]  decl_reg;
    mh_pkg::mh_vec_t            chain_vec   [0:NSTEP];
    logic                       chain_valid [0:NSTEP];
    logic                       chain_ready [0:NSTEP];
    logic [mh_pkg::HEAD_W-1:0]  heading_deg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= mh_pkg::DECL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            decl_reg <= cfg_data;
        end
    end

    mh_pre u_pre
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .x_sample  (s_axis_tdata[mh_pkg::SAMPLE_W-1:0]),
        .y_sample  (s_axis_tdata[mh_pkg::IN_TDATA_W-1:mh_pkg::SAMPLE_W]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_vec   (chain_vec[0])
    );

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_cell
        mh_cell
        #(
            .STEP (k)
        )
        u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_vec    (chain_vec[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_vec   (chain_vec[k+1])
        );
    end

    mh_post u_post
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (chain_valid[NSTEP]),
        .in_ready    (chain_ready[NSTEP]),
        .in_vec      (chain_vec[NSTEP]),
        .declination (decl_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .heading_deg (heading_deg)
    );

    assign m_axis_tdata = {{(mh_pkg::OUT_TDATA_W-mh_pkg::HEAD_W){1'b0}}, heading_deg};

`ifndef ASSERT_OFF
    a_heading_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata < mh_pkg::OUT_TDATA_W'(360)))
        else $error("Heading outside 0 to 359 degrees.");

    a_pad_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tdata[mh_pkg::OUT_TDATA_W-1:mh_pkg::HEAD_W] == '0)
        else $error("Padding bits of the result are not zero.");

    a_decl_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready) |=> $stable(decl_reg))
        else $error("Declination changed without a configuration transaction.");

    a_ready_free : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> chain_valid[0])
        else $error("Input stalled while the first stage is empty.");
`endif

endmodule

@@ hdl/mh_pre.sv @@
// ----------------------------------------------------------------------------
// mh_pre
// Input stage: resolves the axis cases exactly and folds the left half plane
// onto the right before the rotation cells.
// ----------------------------------------------------------------------------
module mh_pre
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [mh_pkg::SAMPLE_W-1:0]  x_sample,
    input  logic signed [mh_pkg::SAMPLE_W-1:0]  y_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mh_pkg::mh_vec_t                     out_vec
);

    logic                                valid_reg;
    mh_pkg::mh_vec_t                     vec_reg;
    mh_pkg::mh_vec_t                     vec_next;
    logic signed [mh_pkg::XW-1:0]        xe;
    logic signed [mh_pkg::XW-1:0]        ye;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    always_comb
    begin
        xe = {{(mh_pkg::XW-mh_pkg::SAMPLE_W){x_sample[mh_pkg::SAMPLE_W-1]}}, x_sample};
        ye = {{(mh_pkg::XW-mh_pkg::SAMPLE_W){y_sample[mh_pkg::SAMPLE_W-1]}}, y_sample};
        vec_next.bypass = 1'b0;
        vec_next.x      = xe <<< mh_pkg::PRE_SHIFT;
        vec_next.y      = ye <<< mh_pkg::PRE_SHIFT;
        vec_next.z      = '0;
        if (y_sample == '0)
        begin
            vec_next.bypass = 1'b1;
            vec_next.z      = x_sample[mh_pkg::SAMPLE_W-1] ? mh_pkg::HALF_TURN : '0;
        end
        else if (x_sample == '0)
        begin
            vec_next.bypass = 1'b1;
            vec_next.z      = y_sample[mh_pkg::SAMPLE_W-1] ? mh_pkg::THREE_QUARTER_TURN
                                                          : mh_pkg::QUARTER_TURN;
        end
        else if (x_sample[mh_pkg::SAMPLE_W-1])
        begin
            vec_next.x = (-xe) <<< mh_pkg::PRE_SHIFT;
            vec_next.y = (-ye) <<< mh_pkg::PRE_SHIFT;
            vec_next.z = mh_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

endmodule

@@ hdl/mh_cell.sv @@
// ----------------------------------------------------------------------------
// mh_cell
// One vectoring CORDIC iteration with its own pipeline register and
// handshake; a chain of these forms the rotation pipeline.
// ----------------------------------------------------------------------------
module mh_cell
#(
    parameter int STEP = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mh_pkg::mh_vec_t  in_vec,
    output logic             out_valid,
    input  logic             out_ready,
    output mh_pkg::mh_vec_t  out_vec
);

    localparam logic [mh_pkg::ZW-1:0] ANGLE = mh_pkg::atan_entry(STEP);

    logic                          valid_reg;
    mh_pkg::mh_vec_t               vec_reg;
    mh_pkg::mh_vec_t               vec_next;
    logic signed [mh_pkg::XW-1:0]  xs;
    logic signed [mh_pkg::XW-1:0]  ys;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    always_comb
    begin
        xs       = $signed(in_vec.x) >>> STEP;
        ys       = $signed(in_vec.y) >>> STEP;
        vec_next = in_vec;
        if (!in_vec.bypass)
        begin
            if (!in_vec.y[mh_pkg::XW-1])
            begin
                vec_next.x = in_vec.x + ys;
                vec_next.y = in_vec.y - xs;
                vec_next.z = in_vec.z + ANGLE;
            end
            else
            begin
                vec_next.x = in_vec.x - ys;
                vec_next.y = in_vec.y + xs;
                vec_next.z = in_vec.z - ANGLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

endmodule

@@ hdl/mh_post.sv @@
// ----------------------------------------------------------------------------
// mh_post
// Output stages: adds the declination, wraps into one full turn and holds
// the whole-degree heading in the output register.
// ----------------------------------------------------------------------------
module mh_post
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  mh_pkg::mh_vec_t                    in_vec,
    input  logic [mh_pkg::DECL_W-1:0]          declination,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mh_pkg::HEAD_W-1:0]          heading_deg
);

    logic                          sum_valid_reg;
    logic                          sum_ready;
    logic signed [mh_pkg::TW-1:0]  total_reg;
    logic signed [mh_pkg::TW-1:0]  total_next;
    logic                          out_valid_reg;
    logic [mh_pkg::HEAD_W-1:0]     heading_reg;
    logic [mh_pkg::HEAD_W-1:0]     heading_next;
    logic [mh_pkg::TW-1:0]         wrapped;

    assign sum_ready   = !out_valid_reg || out_ready;
    assign in_ready    = !sum_valid_reg || sum_ready;
    assign out_valid   = out_valid_reg;
    assign heading_deg = heading_reg;

    always_comb
    begin
        total_next = {{(mh_pkg::TW-mh_pkg::ZW){in_vec.z[mh_pkg::ZW-1]}}, in_vec.z}
                   + {{(mh_pkg::TW-mh_pkg::DECL_W-mh_pkg::DECL_SHIFT){declination[mh_pkg::DECL_W-1]}},
                      declination, {mh_pkg::DECL_SHIFT{1'b0}}};
    end

    always_comb
    begin
        if (total_reg[mh_pkg::TW-1])
        begin
            wrapped = total_reg + mh_pkg::FULL_TURN;
        end
        else if (total_reg >= mh_pkg::FULL_TURN)
        begin
            wrapped = total_reg - mh_pkg::FULL_TURN;
        end
        else
        begin
            wrapped = total_reg;
        end
        heading_next = wrapped[mh_pkg::FRAC_W +: mh_pkg::HEAD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sum_valid_reg <= in_valid;
            end
            if (sum_ready)
            begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            total_reg <= total_next;
        end
        if (sum_ready && sum_valid_reg)
        begin
            heading_reg <= heading_next;
        end
    end

endmodule
